[rtl/core/clsr_pkg.sv]
// ----------------------------------------------------------------------------
// clsr_pkg: shared constants and types for the combined LCG shuffle generator
// Holds the generator moduli and multipliers, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package clsr_pkg;

  // Default shuffle table depth
  localparam int unsigned TABLE_DEPTH_DEF = 32;

  // Generator moduli and multipliers
  localparam logic [31:0] MOD_ONE = 32'd2147483563;
  localparam logic [31:0] MOD_TWO = 32'd2147483399;
  localparam logic [15:0] MUL_ONE = 16'd40014;
  localparam logic [15:0] MUL_TWO = 16'd40692;

  // 2^31 mod each modulus, used to fold the high product bits back in
  localparam logic [7:0] FOLD_ONE = 8'd85;
  localparam logic [7:0] FOLD_TWO = 8'd249;

  // Output range top and reset seed of the second generator
  localparam logic [31:0] WRAP_TOP = 32'd2147483562;
  localparam logic [31:0] SEED_TWO = 32'd123456789;

  // Warm-up steps beyond the table depth
  localparam int unsigned WARM_EXTRA = 8;

  // Fixed-point shift of the slot reciprocal
  localparam int unsigned RECIP_SHIFT = 40;

  // Controller to datapath commands
  typedef struct packed {
    logic load_seed;  // load both generators from the seed magnitude
    logic mul;        // form generator and slot products
    logic fold;       // first modular fold, slot product correction
    logic fin_warm;   // finish a warm-up step, fill the table
    logic fin_draw;   // finish both generators, read the chosen slot
    logic out_load;   // write back the slot and load the output beat
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic warm_last;  // current warm-up step is the final one
    logic out_free;   // output register can take a beat this cycle
  } sts_t;

endpackage

[rtl/core/clsr_ctrl.sv]
// ----------------------------------------------------------------------------
// clsr_ctrl: sequencer for seeding and drawing
// Steps the datapath through the warm-up loop after a seed request and
// through the four phases of a draw, and owns the input handshake.
// ----------------------------------------------------------------------------
module clsr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           kind,
  input  clsr_pkg::sts_t sts,
  output clsr_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    W_MUL,
    W_FOLD,
    W_FIN,
    D_MUL,
    D_FOLD,
    D_FIN,
    D_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take a new beat when idle or while the last draw retires
  assign s_tready = (state == IDLE) || ((state == D_OUT) && sts.out_free);
  assign accept   = s_tvalid && s_tready;

  // Decode commands from the current phase
  always_comb begin
    cmd           = '0;
    cmd.load_seed = accept && kind;
    case (state)
      W_MUL, D_MUL:   cmd.mul      = 1'b1;
      W_FOLD, D_FOLD: cmd.fold     = 1'b1;
      W_FIN:          cmd.fin_warm = 1'b1;
      D_FIN:          cmd.fin_draw = 1'b1;
      D_OUT:          cmd.out_load = sts.out_free;
      default:        cmd.mul      = 1'b0;
    endcase
  end

  // Next phase
  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) state_next = kind ? W_MUL : D_MUL;
      end
      W_MUL:  state_next = W_FOLD;
      W_FOLD: state_next = W_FIN;
      W_FIN:  state_next = sts.warm_last ? D_MUL : W_MUL;
      D_MUL:  state_next = D_FOLD;
      D_FOLD: state_next = D_FIN;
      D_FIN:  state_next = D_OUT;
      D_OUT: begin
        if (accept) begin
          state_next = kind ? W_MUL : D_MUL;
        end else if (sts.out_free) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/clsr_datapath.sv]
// ----------------------------------------------------------------------------
// clsr_datapath: generators, shuffle table and output register
// Multiplies each generator by its constant, reduces the product in two
// folds, picks a table slot from the previous output by reciprocal
// multiplication, and forms the wrapped difference.
// ----------------------------------------------------------------------------
module clsr_datapath #(
  parameter int unsigned TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  clsr_pkg::cmd_t cmd,
  input  logic [31:0]    seed,
  output clsr_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [30:0]    out_data
);

  localparam int unsigned IDXW     = $clog2(TABLE_DEPTH);
  localparam int unsigned QW       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW       = $clog2(TABLE_DEPTH + clsr_pkg::WARM_EXTRA);
  localparam logic [31:0] SLOT_DIV = 32'(1 + (clsr_pkg::WRAP_TOP - 1) / TABLE_DEPTH);
  localparam logic [63:0] RECIP_FULL = (64'd1 << clsr_pkg::RECIP_SHIFT) / SLOT_DIV;
  localparam int unsigned RW       = $clog2(RECIP_FULL + 1);
  localparam int unsigned PW       = 31 + RW;
  localparam logic [RW-1:0] RECIP  = RECIP_FULL[RW-1:0];
  localparam logic [CW-1:0] WARM_TOP = CW'(TABLE_DEPTH + clsr_pkg::WARM_EXTRA - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
  localparam logic [QW-1:0] SLOT_MAX = QW'(TABLE_DEPTH - 1);

  // Fold the bits above 2^31 back in: 2^31 is congruent to c
  function automatic logic [31:0] mod_fold(input logic [47:0] p, input logic [7:0] c);
    logic [31:0] hi_part;
    hi_part = 32'(p[47:31]) * 32'(c);
    return {1'b0, p[30:0]} + hi_part;
  endfunction

  // Second fold and final conditional subtract
  function automatic logic [30:0] mod_final(input logic [31:0] y, input logic [7:0] c,
                                            input logic [31:0] m);
    logic [31:0] z;
    z = {1'b0, y[30:0]} + (y[31] ? 32'(c) : 32'd0);
    if (z >= m) z = z - m;
    return z[30:0];
  endfunction

  logic [31:0]          gen1;
  logic [31:0]          gen2;
  logic [30:0]          last_out;
  logic [47:0]          prod1;
  logic [47:0]          prod2;
  logic [PW-1:0]        prod_r;
  logic [31:0]          fold1;
  logic [31:0]          fold2;
  logic [QW-1:0]        q0;
  logic [30:0]          qd;
  logic [CW-1:0]        warm_cnt;
  logic [IDXW-1:0]      slot;
  logic [30:0]          rdata;
  logic                 rvld;
  logic [TABLE_DEPTH-1:0] vld;
  logic [30:0]          mem [TABLE_DEPTH];

  logic [31:0]          magnitude;
  logic [30:0]          gen1_fin;
  logic [30:0]          gen2_fin;
  logic [30:0]          rem;
  logic [QW-1:0]        q_fix;
  logic [IDXW-1:0]      slot_fix;
  logic [32:0]          diff;
  logic [32:0]          diff_wrap;
  logic [30:0]          result;
  logic                 warm_we;
  logic                 we;
  logic [IDXW-1:0]      waddr;
  logic [30:0]          wdata;

  // Seed magnitude, zero taken as one
  always_comb begin
    magnitude = seed[31] ? (~seed + 32'd1) : seed;
    if (magnitude == 32'd0) magnitude = 32'd1;
  end

  // Finished generator values
  assign gen1_fin = mod_final(fold1, clsr_pkg::FOLD_ONE, clsr_pkg::MOD_ONE);
  assign gen2_fin = mod_final(fold2, clsr_pkg::FOLD_TWO, clsr_pkg::MOD_TWO);

  // Correct the reciprocal quotient by one and saturate to the last slot
  always_comb begin
    rem   = last_out - qd;
    q_fix = q0 + ((32'(rem) >= SLOT_DIV) ? QW'(1) : QW'(0));
    if (q_fix > SLOT_MAX) begin
      slot_fix = SLOT_MAX[IDXW-1:0];
    end else begin
      slot_fix = q_fix[IDXW-1:0];
    end
  end

  // Wrapped difference of the old slot and the second generator
  always_comb begin
    diff      = {2'b00, (rvld ? rdata : 31'd0)} - {1'b0, gen2};
    diff_wrap = diff;
    if (diff[32] || (diff == 33'd0)) diff_wrap = diff + {1'b0, clsr_pkg::WRAP_TOP};
    result    = diff_wrap[30:0];
  end

  // Table write port: warm-up fill or draw write-back
  assign warm_we = cmd.fin_warm && (warm_cnt < DEPTH_C);
  assign we      = warm_we || cmd.out_load;
  assign waddr   = cmd.out_load ? slot : warm_cnt[IDXW-1:0];
  assign wdata   = cmd.out_load ? gen1[30:0] : gen1_fin;

  assign sts.warm_last = (warm_cnt == '0);
  assign sts.out_free  = !out_valid || out_ready;

  // Generators, products and slot arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      gen1     <= 32'd1;
      gen2     <= clsr_pkg::SEED_TWO;
      last_out <= '0;
      warm_cnt <= '0;
    end else begin
      if (cmd.load_seed) begin
        gen1     <= magnitude;
        gen2     <= magnitude;
        warm_cnt <= WARM_TOP;
      end
      if (cmd.fin_warm) begin
        gen1 <= {1'b0, gen1_fin};
        if (warm_cnt == '0) begin
          last_out <= gen1_fin;
        end else begin
          warm_cnt <= warm_cnt - CW'(1);
        end
      end
      if (cmd.fin_draw) begin
        gen1 <= {1'b0, gen1_fin};
        gen2 <= {1'b0, gen2_fin};
      end
      if (cmd.out_load) last_out <= result;
    end
  end

  // Pipeline payload registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod1  <= 48'(clsr_pkg::MUL_ONE) * 48'(gen1);
      prod2  <= 48'(clsr_pkg::MUL_TWO) * 48'(gen2);
      prod_r <= PW'(last_out) * PW'(RECIP);
    end
    if (cmd.fold) begin
      fold1 <= mod_fold(prod1, clsr_pkg::FOLD_ONE);
      fold2 <= mod_fold(prod2, clsr_pkg::FOLD_TWO);
      q0    <= QW'(prod_r >> clsr_pkg::RECIP_SHIFT);
      qd    <= 31'(32'(QW'(prod_r >> clsr_pkg::RECIP_SHIFT)) * SLOT_DIV);
    end
    if (cmd.fin_draw) slot <= slot_fix;
  end

  // Shuffle table memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.fin_draw) begin
      rdata <= mem[slot_fix];
      rvld  <= vld[slot_fix];
    end
  end

  // Written-entry marks; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= result;
  end

endmodule

[rtl/core/combined_lcg_shuffle_rng.sv]
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng: two-generator LCG with shuffle table
// Uniform integer generator in 1..2147483562 from two combined
// multiplicative congruential generators and a shuffle table.
//
//   Channel  Direction  Signals                      Contents
//   s_       in         tvalid tready tdata tuser    seed_value, kind
//   m_       out        tvalid tready tdata          deviate
//
// A draw steps through multiply, first fold, final reduce with table
// read, write-back with output load; the next beat is taken in the last one.
// A seed request adds TABLE_DEPTH+8 warm-up steps, each a multiply, fold
// and final reduce on the single shared reduction chain.
// After reset the table reads as zeros; no clearing pass is needed.
// A stalled output holds the draw in its last phase; the input waits.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng #(
  parameter int unsigned TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] seed_value
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [30:0] deviate, [31] zero
);

  clsr_pkg::cmd_t cmd;
  clsr_pkg::sts_t sts;
  logic [30:0]    deviate;

  // Sequencer
  clsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and table
  clsr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .seed      (s_tdata),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (deviate)
  );

  assign m_tdata = {1'b0, deviate};

endmodule
